// ----- hdl/cbf_pkg.sv -----
package cbf_pkg;

   localparam int COUNT_DIGITS = 6;
   localparam int CNT_W        = 4 * COUNT_DIGITS;
   localparam int DIG_W        = (COUNT_DIGITS > 1) ? $clog2(COUNT_DIGITS) : 1;

   // output slots of one request, in emission order
   localparam int SLOT_PTAB      = COUNT_DIGITS;
   localparam int SLOT_DOLLAR    = COUNT_DIGITS + 1;
   localparam int SLOT_META_M    = COUNT_DIGITS + 2;
   localparam int SLOT_META_DASH = COUNT_DIGITS + 3;
   localparam int SLOT_CARET     = COUNT_DIGITS + 4;
   localparam int SLOT_CHAR      = COUNT_DIGITS + 5;
   localparam int SLOT_N         = COUNT_DIGITS + 6;
   localparam int SLOT_W         = $clog2(SLOT_N);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NUMBER_NONBLANK  = 3'd0,
      CSR_NUMBER_ALL       = 3'd1,
      CSR_SHOW_ENDS        = 3'd2,
      CSR_SQUEEZE_BLANK    = 3'd3,
      CSR_SHOW_TABS        = 3'd4,
      CSR_SHOW_NONPRINTING = 3'd5
   } csr_index_type;

   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_M      = 8'h4D;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_I      = 8'h49;
   localparam logic [7:0] CH_TILDE  = 8'd126;
   localparam logic [7:0] CH_DEL    = 8'd127;
   localparam logic [7:0] CTL_END   = 8'd32;
   localparam logic [7:0] META_END  = 8'd160;
   localparam logic [7:0] CARET_OFS = 8'd64;

   localparam logic [CNT_W-1:0] COUNT_ONE = CNT_W'(1);

   typedef struct packed {
      logic number_nonblank;
      logic number_all;
      logic show_ends;
      logic squeeze_blank;
      logic show_tabs;
      logic show_nonprinting;
   } cfg_type;

   typedef struct packed {
      logic [CNT_W-1:0]  count;
      logic              spaces;
      logic [7:0]        char_byte;
      logic [SLOT_N-1:0] mask;
   } entry_type;

   typedef struct packed {
      logic not_full;
      logic not_empty;
   } queue_status_type;

   function automatic logic [3:0] bcd_digit(input logic [CNT_W-1:0] v, input int p);
      logic [3:0] d;
      d = v[4*p +: 4];
      return (d > 4'd9) ? 4'd9 : d;
   endfunction

   // saturating BCD increment
   function automatic logic [CNT_W-1:0] bcd_advance(input logic [CNT_W-1:0] v);
      logic [CNT_W-1:0] res;
      logic [3:0]       d;
      logic             carry;
      logic             all_nine;
      res      = '0;
      carry    = 1'b1;
      all_nine = 1'b1;
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         if (v[4*i +: 4] < 4'd9) all_nine = 1'b0;
      end
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         d = bcd_digit(v, i);
         if (carry) begin
            if (d == 4'd9) begin
               d = 4'd0;
            end else begin
               d     = d + 4'd1;
               carry = 1'b0;
            end
         end
         res[4*i +: 4] = d;
      end
      return all_nine ? v : res;
   endfunction

endpackage

// ----- hdl/cbf_stream_if.sv -----
interface cbf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       file_start;

   modport source (output valid, output in_byte, output file_start, input ready);
   modport sink   (input valid, input in_byte, input file_start, output ready);
endinterface

interface cbf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;

   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ----- hdl/cbf_front.sv -----
module cbf_front (
   input  logic                      clock,
   input  logic                      reset,
   input  cbf_pkg::cfg_type          cfg,
   cbf_req_if.sink                   req_chan,
   input  cbf_pkg::queue_status_type q_status,
   output logic                      push,
   output cbf_pkg::entry_type        push_data
);
   import cbf_pkg::*;

   logic             prev_ff, prev_in;
   logic [1:0]       blank_ff, blank_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             accept;
   logic             is_nl;
   logic             eff_prev;
   logic [1:0]       eff_blank;
   logic [CNT_W-1:0] eff_count;
   logic             nb, na;
   logic             squeeze_hit;
   logic [1:0]       blank_next;
   logic             drop;
   logic             do_number, do_spaces;
   logic             tab_caret;
   logic [7:0]       ch1;
   logic             ctl, meta, np_range;
   logic [7:0]       final_char;

   assign req_chan.ready = q_status.not_full;
   assign accept         = req_chan.valid & req_chan.ready;

   always_comb begin
      is_nl     = (req_chan.in_byte == CH_NL);
      eff_prev  = req_chan.file_start | prev_ff;
      eff_blank = req_chan.file_start ? 2'd0 : blank_ff;
      eff_count = req_chan.file_start ? COUNT_ONE : count_ff;
      nb        = cfg.number_nonblank;
      na        = cfg.number_all & ~nb;

      squeeze_hit = cfg.squeeze_blank & is_nl & eff_prev;
      if (squeeze_hit)
         blank_next = (eff_blank == 2'd3) ? 2'd3 : eff_blank + 2'd1;
      else
         blank_next = 2'd0;
      drop = squeeze_hit && (blank_next > 2'd1);

      do_number = eff_prev & ((nb & ~is_nl) | na);
      do_spaces = ~do_number & eff_prev & cfg.show_ends & nb;

      tab_caret = cfg.show_tabs && (req_chan.in_byte == CH_TAB);
      ch1       = tab_caret ? CH_I : req_chan.in_byte;
      ctl       = (ch1 < CTL_END) && (ch1 != CH_NL) && (ch1 != CH_TAB);
      meta      = cfg.show_nonprinting && (ch1 > CH_DEL) && (ch1 < META_END);
      np_range  = ((ch1 < CTL_END) || ((ch1 > CH_TILDE) && (ch1 < META_END)))
                  && (ch1 != CH_NL) && (ch1 != CH_TAB);
      if (cfg.show_nonprinting && np_range)
         final_char = (ch1 > CH_TILDE) ? ch1 - CARET_OFS : ch1 + CARET_OFS;
      else
         final_char = ch1;

      push_data                        = '0;
      push_data.count                  = eff_count;
      push_data.spaces                 = do_spaces;
      push_data.char_byte              = final_char;
      push_data.mask[SLOT_PTAB:0]      = {(SLOT_PTAB+1){do_number | do_spaces}};
      push_data.mask[SLOT_DOLLAR]      = cfg.show_ends & is_nl;
      push_data.mask[SLOT_META_M]      = meta;
      push_data.mask[SLOT_META_DASH]   = meta;
      push_data.mask[SLOT_CARET]       = tab_caret | meta
                                         | (cfg.show_nonprinting & (ctl | (ch1 == CH_DEL)));
      push_data.mask[SLOT_CHAR]        = 1'b1;

      push = accept & ~drop;

      prev_in  = prev_ff;
      blank_in = blank_ff;
      count_in = count_ff;
      if (accept) begin
         blank_in = blank_next;
         if (drop) begin
            prev_in  = eff_prev;
            count_in = eff_count;
         end else begin
            prev_in  = is_nl;
            count_in = do_number ? bcd_advance(eff_count) : eff_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= 1'b1;
         blank_ff <= 2'd0;
         count_ff <= COUNT_ONE;
      end else begin
         prev_ff  <= prev_in;
         blank_ff <= blank_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- hdl/cbf_queue.sv -----
module cbf_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  cbf_pkg::entry_type        push_data,
   input  logic                      pop,
   output cbf_pkg::entry_type        pop_data,
   output cbf_pkg::queue_status_type status
);
   import cbf_pkg::*;

   entry_type         mem [QUEUE_DEPTH];
   entry_type         pop_data_ff;
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   fill_ff, fill_in;

   always_comb begin
      status.not_full  = (fill_ff != (QPTR_W+1)'(QUEUE_DEPTH));
      status.not_empty = (fill_ff != '0);
      pop_data         = pop_data_ff;

      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop)
         fill_in = fill_ff + 1'b1;
      else if (pop && !push)
         fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_data;
   end

   // read register follows the next head entry; bypass when the push lands there
   always_ff @(posedge clock) begin
      if (push && (wr_ptr_ff == rd_ptr_in)) pop_data_ff <= push_data;
      else                                  pop_data_ff <= mem[rd_ptr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ----- hdl/cbf_back.sv -----
module cbf_back (
   input  logic                      clock,
   input  logic                      reset,
   input  cbf_pkg::entry_type        q_data,
   input  cbf_pkg::queue_status_type q_status,
   output logic                      pop,
   cbf_rsp_if.source                 rsp_chan
);
   import cbf_pkg::*;

   entry_type         cur_ff, cur_in;
   logic              cur_valid_ff, cur_valid_in;

   logic [SLOT_W-1:0] slot;
   logic [SLOT_N-1:0] rest;
   logic              last;
   logic              fire;
   logic [7:0]        digit_chars [COUNT_DIGITS];

   // lowest pending slot goes out first
   always_comb begin : pick
      logic found;
      found = 1'b0;
      slot  = '0;
      for (int i = 0; i < SLOT_N; i++) begin
         if (!found && cur_ff.mask[i]) begin
            slot  = SLOT_W'(i);
            found = 1'b1;
         end
      end
      rest = cur_ff.mask & (cur_ff.mask - 1'b1);
      last = (rest == '0);
   end

   // digit slot 0 holds the most significant digit; leading zeros blank
   always_comb begin : digits
      logic       lead;
      logic [3:0] d;
      lead = 1'b1;
      for (int i = COUNT_DIGITS - 1; i >= 0; i--) begin
         d = bcd_digit(cur_ff.count, i);
         if (cur_ff.spaces) begin
            digit_chars[COUNT_DIGITS-1-i] = CH_SPACE;
         end else if (lead && (d == 4'd0) && (i != 0)) begin
            digit_chars[COUNT_DIGITS-1-i] = CH_SPACE;
         end else begin
            lead = 1'b0;
            digit_chars[COUNT_DIGITS-1-i] = CH_ZERO + {4'd0, d};
         end
      end
   end

   always_comb begin
      rsp_chan.valid       = cur_valid_ff;
      rsp_chan.last_of_run = last;
      if (slot < SLOT_W'(COUNT_DIGITS)) begin
         rsp_chan.out_byte = digit_chars[slot[DIG_W-1:0]];
      end else begin
         unique case (slot)
            SLOT_W'(SLOT_PTAB):      rsp_chan.out_byte = CH_TAB;
            SLOT_W'(SLOT_DOLLAR):    rsp_chan.out_byte = CH_DOLLAR;
            SLOT_W'(SLOT_META_M):    rsp_chan.out_byte = CH_M;
            SLOT_W'(SLOT_META_DASH): rsp_chan.out_byte = CH_DASH;
            SLOT_W'(SLOT_CARET):     rsp_chan.out_byte = CH_CARET;
            default:                 rsp_chan.out_byte = cur_ff.char_byte;
         endcase
      end

      fire = cur_valid_ff & rsp_chan.ready;
      pop  = q_status.not_empty & (~cur_valid_ff | (fire & last));

      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      if (pop) begin
         cur_in       = q_data;
         cur_valid_in = 1'b1;
      end else if (fire) begin
         cur_in.mask  = rest;
         cur_valid_in = ~last;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) cur_valid_ff <= 1'b0;
      else       cur_valid_ff <= cur_valid_in;
   end

endmodule

// ----- hdl/cat_style_byte_formatter_unit.sv -----
// Display filter for a byte stream: each request byte turns into a run of one to eleven
// response bytes (line number prefix, end marker, caret escapes, the byte itself), the
// final one flagged last_of_run; a newline removed by blank squeezing yields no response.
// Responses leave at one byte per clock from the back-end sequencer while the receiver is
// ready, so plain text flows at one byte per cycle. The front end classifies one request
// per cycle into a four-entry queue, so requests keep being taken while the response side
// is stalled, until that queue fills. Write the control registers only while the block
// is idle.
module cat_style_byte_formatter_unit (
   input  logic                             clock,
   input  logic                             reset,
   cbf_req_if.sink                          req_chan,
   cbf_rsp_if.source                        rsp_chan,
   input  logic                             csr_write_en,
   input  logic [cbf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cbf_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import cbf_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   queue_status_type q_status;
   logic             q_push, q_pop;
   entry_type        q_push_data, q_pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_NUMBER_NONBLANK:  cfg_in.number_nonblank  = csr_write_data[0];
            CSR_NUMBER_ALL:       cfg_in.number_all       = csr_write_data[0];
            CSR_SHOW_ENDS:        cfg_in.show_ends        = csr_write_data[0];
            CSR_SQUEEZE_BLANK:    cfg_in.squeeze_blank    = csr_write_data[0];
            CSR_SHOW_TABS:        cfg_in.show_tabs        = csr_write_data[0];
            CSR_SHOW_NONPRINTING: cfg_in.show_nonprinting = csr_write_data[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= '0;
      else       cfg_ff <= cfg_in;
   end

   cbf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_chan  (req_chan),
      .q_status  (q_status),
      .push      (q_push),
      .push_data (q_push_data)
   );

   cbf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   cbf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_data   (q_pop_data),
      .q_status (q_status),
      .pop      (q_pop),
      .rsp_chan (rsp_chan)
   );

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> q_status.not_full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_status.not_empty)
      else $error("queue read while empty");

   a_drain_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.last_of_run && !q_status.not_empty)
      |=> !rsp_chan.valid)
      else $error("response shown with nothing queued");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("response valid right after reset");
`endif

endmodule

// ----- tb/cbf_stream_checker.sv -----
`timescale 1ns / 100ps
module cbf_stream_checker
   import cbf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   cbf_req_if                     req_mon,
   cbf_rsp_if                     rsp_mon,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output int                     mismatches,
   output int                     bytes_pending,
   output int                     requests_seen,
   output int                     bytes_checked
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [7:0] text;
      logic       last;
   } out_byte_type;

   cfg_type          settings;
   logic             after_newline;
   logic [1:0]       blank_streak;
   logic [CNT_W-1:0] line_no;
   out_byte_type     expected_bytes [$];

   // next line number in BCD, held at all nines
   function automatic logic [CNT_W-1:0] next_line_no(input logic [CNT_W-1:0] cur);
      logic [CNT_W-1:0] nxt;
      logic [3:0]       digit;
      logic             carry;
      logic             saturated;
      nxt       = '0;
      carry     = 1'b1;
      saturated = 1'b1;
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         if (cur[4*i +: 4] < 4'd9) saturated = 1'b0;
      end
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         digit = (cur[4*i +: 4] > 4'd9) ? 4'd9 : cur[4*i +: 4];
         if (carry) begin
            if (digit == 4'd9) begin
               digit = 4'd0;
            end else begin
               digit = digit + 4'd1;
               carry = 1'b0;
            end
         end
         nxt[4*i +: 4] = digit;
      end
      return saturated ? cur : nxt;
   endfunction

   // expected output run for one request byte
   task automatic format_request(input logic [7:0] in_byte, input logic file_start);
      logic [7:0] run [$];
      logic [7:0] ch;
      logic [3:0] digit;
      logic       is_nl;
      logic       by_nonblank;
      logic       by_all;
      logic       lead;
      logic       ctl;
      is_nl       = (in_byte == CH_NL);
      by_nonblank = settings.number_nonblank;
      by_all      = settings.number_all && !by_nonblank;
      if (file_start) begin
         after_newline = 1'b1;
         blank_streak  = '0;
         line_no       = COUNT_ONE;
      end
      if (settings.squeeze_blank && is_nl && after_newline) begin
         if (blank_streak != 2'd3) blank_streak = blank_streak + 2'd1;
         if (blank_streak > 2'd1) return;
      end else begin
         blank_streak = '0;
      end
      if (after_newline && ((by_nonblank && !is_nl) || by_all)) begin
         lead = 1'b1;
         for (int i = COUNT_DIGITS - 1; i >= 0; i--) begin
            digit = (line_no[4*i +: 4] > 4'd9) ? 4'd9 : line_no[4*i +: 4];
            if (lead && digit == 4'd0 && i != 0) begin
               run.push_back(CH_SPACE);
            end else begin
               lead = 1'b0;
               run.push_back(CH_ZERO + 8'(digit));
            end
         end
         run.push_back(CH_TAB);
         line_no = next_line_no(line_no);
      end else if (after_newline && settings.show_ends && by_nonblank) begin
         // unnumbered blank line keeps the text column aligned
         for (int i = 0; i < COUNT_DIGITS; i++) run.push_back(CH_SPACE);
         run.push_back(CH_TAB);
      end
      if (settings.show_ends && is_nl) run.push_back(CH_DOLLAR);
      ch = in_byte;
      if (settings.show_tabs && ch == CH_TAB) begin
         run.push_back(CH_CARET);
         ch = CH_I;
      end
      if (settings.show_nonprinting) begin
         ctl = (ch < CTL_END) && ch != CH_NL && ch != CH_TAB;
         if (ch > CH_DEL && ch < META_END) begin
            run.push_back(CH_M);
            run.push_back(CH_DASH);
            run.push_back(CH_CARET);
         end
         if (ctl || ch == CH_DEL) run.push_back(CH_CARET);
         if ((ch < CTL_END || (ch > CH_TILDE && ch < META_END)) && ch != CH_NL && ch != CH_TAB)
            ch = (ch > CH_TILDE) ? ch - CARET_OFS : ch + CARET_OFS;
      end
      run.push_back(ch);
      after_newline = is_nl;
      foreach (run[k]) expected_bytes.push_back('{text: run[k], last: (k == run.size() - 1)});
   endtask

   always @(posedge clock) begin
      out_byte_type want;
      if (reset) begin
         settings      = '0;
         after_newline = 1'b1;
         blank_streak  = '0;
         line_no       = COUNT_ONE;
         expected_bytes.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_NUMBER_NONBLANK:  settings.number_nonblank  = csr_write_data[0];
               CSR_NUMBER_ALL:       settings.number_all       = csr_write_data[0];
               CSR_SHOW_ENDS:        settings.show_ends        = csr_write_data[0];
               CSR_SQUEEZE_BLANK:    settings.squeeze_blank    = csr_write_data[0];
               CSR_SHOW_TABS:        settings.show_tabs        = csr_write_data[0];
               CSR_SHOW_NONPRINTING: settings.show_nonprinting = csr_write_data[0];
               default: ;
            endcase
         end
         // responses first: a response never belongs to a request taken on the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            bytes_checked++;
            if (expected_bytes.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("ERROR t=%0t: unexpected output byte %02h last %0b", $realtime,
                           rsp_mon.out_byte, rsp_mon.last_of_run);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_mon.out_byte !== want.text || rsp_mon.last_of_run !== want.last) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("ERROR t=%0t: output byte %0d expected %02h last %0b, got %02h last %0b",
                              $realtime, bytes_checked, want.text, want.last,
                              rsp_mon.out_byte, rsp_mon.last_of_run);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            requests_seen++;
            format_request(req_mon.in_byte, req_mon.file_start);
         end
      end
      bytes_pending <= expected_bytes.size();
   end

endmodule

// ----- tb/cat_style_byte_formatter_unit_tb.sv -----
`timescale 1ns / 100ps
module cat_style_byte_formatter_unit_tb;
   import cbf_pkg::*;

   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 33;
   localparam int HOLD_PHASE      = 4;
   localparam int LONG_HOLD       = 120;
   localparam int DRAIN_GAP       = 20;
   localparam int TAIL_GAP        = 30;
   localparam int NUM_DIRECTED    = 22;
   localparam int REFILE_AT       = 18;

   localparam logic [7:0] DIRECTED [NUM_DIRECTED] = '{
      8'h61, 8'h00, CH_DEL, 8'h80, 8'h9F, META_END, 8'hFF, CH_TAB,
      CH_NL, CH_NL, CH_NL, CH_NL, CH_NL, 8'h62, 8'h1F, CH_TILDE,
      CH_SPACE, CH_NL, CH_NL, CH_NL, 8'h7A, CH_NL
   };

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;
   logic                   hold_request = 1'b0;
   int                     req_idle_pct = 0;
   int                     rsp_stall_pct = 0;
   int                     settings_used = 0;
   int                     mismatches;
   int                     bytes_pending;
   int                     requests_seen;
   int                     bytes_checked;

   cbf_req_if req_bus ();
   cbf_rsp_if rsp_bus ();

   cat_style_byte_formatter_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_bus),
      .rsp_chan       (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   cbf_stream_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .mismatches     (mismatches),
      .bytes_pending  (bytes_pending),
      .requests_seen  (requests_seen),
      .bytes_checked  (bytes_checked)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // response side: random stalls plus one long hold-off on request
   initial begin : rsp_side
      int   hold_left;
      logic hold_taken;
      hold_left     = 0;
      hold_taken    = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (hold_request && !hold_taken) begin
            hold_left     = LONG_HOLD;
            hold_taken    = 1'b1;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (!hold_request) hold_taken = 1'b0;
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   initial begin
      #400000;
      $display("timeout: %0d output bytes still outstanding", bytes_pending);
      $display("cat_style_byte_formatter_unit: mismatch");
      $finish;
   end

   task automatic put_reg(input csr_index_type idx, input logic value);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      @(posedge clock);
   endtask

   task automatic apply_settings(input cfg_type s);
      put_reg(CSR_NUMBER_NONBLANK, s.number_nonblank);
      put_reg(CSR_NUMBER_ALL, s.number_all);
      put_reg(CSR_SHOW_ENDS, s.show_ends);
      put_reg(CSR_SQUEEZE_BLANK, s.squeeze_blank);
      put_reg(CSR_SHOW_TABS, s.show_tabs);
      put_reg(CSR_SHOW_NONPRINTING, s.show_nonprinting);
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   task automatic send_request(input logic [7:0] value, input logic first);
      while (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.in_byte    <= value;
      req_bus.file_start <= first;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // idle the request side until every expected byte is out, then let squeezed
   // newlines still in flight settle
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (bytes_pending != 0) @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_text_byte();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 45) return 8'($urandom_range(126, 33));
      if (roll < 55) return CH_SPACE;
      if (roll < 63) return CH_TAB;
      if (roll < 73) return 8'($urandom_range(31, 0));
      if (roll < 83) return 8'($urandom_range(159, 127));
      return 8'($urandom_range(255, 160));
   endfunction

   // one text line, sometimes blank, sometimes followed by a run of blank lines;
   // a few lines are raw noise
   task automatic send_line(inout int sent);
      int   len;
      logic noisy;
      noisy = ($urandom_range(9) == 0);
      len   = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
      for (int i = 0; i < len; i++) begin
         send_request(noisy ? 8'($urandom) : pick_text_byte(), $urandom_range(29) == 0);
         sent++;
      end
      send_request(CH_NL, $urandom_range(29) == 0);
      sent++;
      if ($urandom_range(4) == 0) begin
         repeat ($urandom_range(4, 1)) begin
            send_request(CH_NL, 1'b0);
            sent++;
         end
      end
   endtask

   initial begin
      cfg_type settings;
      int      sent;
      logic    paused;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.in_byte    = '0;
      req_bus.file_start = 1'b0;
      csr_write_en       = 1'b0;
      csr_index          = '0;
      csr_write_data     = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: every option on, control and meta bytes, long blank runs, refile
      apply_settings('1);
      for (int i = 0; i < NUM_DIRECTED; i++)
         send_request(DIRECTED[i], i == 0 || i == REFILE_AT);
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p % 4)
            0: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               req_idle_pct  = 66;
               rsp_stall_pct = 0;
            end
            2: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 66;
            end
            default: begin
               req_idle_pct  = 24;
               rsp_stall_pct = 24;
            end
         endcase
         settings = '0;
         case (p)
            0: ;
            1: settings = '1;
            2: begin
               settings.number_all = 1'b1;
               settings.show_ends  = 1'b1;
            end
            3: begin
               settings.number_nonblank = 1'b1;
               settings.show_ends       = 1'b1;
               settings.squeeze_blank   = 1'b1;
            end
            4: begin
               settings.show_tabs        = 1'b1;
               settings.show_nonprinting = 1'b1;
               settings.squeeze_blank    = 1'b1;
            end
            5: begin
               settings.number_all       = 1'b1;
               settings.squeeze_blank    = 1'b1;
               settings.show_nonprinting = 1'b1;
            end
            6: settings.number_nonblank = 1'b1;
            default: settings = cfg_type'($urandom_range(63));
         endcase
         apply_settings(settings);
         hold_request = (p == HOLD_PHASE);
         paused       = 1'b0;
         sent         = 0;
         while (sent < ITEMS_PER_PHASE) begin
            send_line(sent);
            if (p == HOLD_PHASE && !paused && sent >= ITEMS_PER_PHASE / 2) begin
               drain();
               paused = 1'b1;
            end
         end
         hold_request = 1'b0;
         drain();
      end

      repeat (TAIL_GAP) @(posedge clock);
      $display("run: %0d input bytes, %0d output bytes, %0d register settings", requests_seen,
               bytes_checked, settings_used);
      $display("run: flow control with free flow, sender gaps, receiver stalls and a long hold");
      if (mismatches == 0 && bytes_pending == 0) begin
         $display("cat_style_byte_formatter_unit: match");
      end else begin
         $display("cat_style_byte_formatter_unit: mismatch");
      end
      $finish;
   end

endmodule
